// ===== hw/rtl/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helper functions of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int IN_W        = 32;
  localparam int STEP_BITS   = 8;

  localparam int DIV_CYCLES  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W       = DIV_CYCLES * STEP_BITS;
  localparam int CYC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = $clog2(MAX_DIGITS);

  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int OUT_W       = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } rdc_cmd_t;

  typedef struct packed {
    logic digit_end;
    logic conv_done;
    logic emit_last;
    logic out_free;
  } rdc_status_t;

  function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) b = RADIX_MIN;
    if (r > RADIX_MAX) b = RADIX_MAX;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer that steps the divider for each digit and then drains the digits.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdc_pkg::rdc_status_t sts,
  output rdc_pkg::rdc_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.digit_end && sts.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, shift-subtract divider, digit buffer and output register.
// ----------------------------------------------------------------------------
module rdc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0]         cfg_wdata,
  input  logic [rdc_pkg::IN_W-1:0]            in_value,
  input  rdc_pkg::rdc_cmd_t                   cmd,
  output rdc_pkg::rdc_status_t                sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rdc_pkg::CHAR_W-1:0]          out_char,
  output logic                                out_last
);

  logic [rdc_pkg::RADIX_W-1:0] radix;
  logic [rdc_pkg::RADIX_W-1:0] base;
  logic [rdc_pkg::DIV_W-1:0]   quot;
  logic [rdc_pkg::DIV_W-1:0]   quot_next;
  logic [rdc_pkg::DIGIT_W-1:0] rem;
  logic [rdc_pkg::DIGIT_W-1:0] rem_next;
  logic [rdc_pkg::CYC_W-1:0]   cyc;
  logic [rdc_pkg::CNT_W-1:0]   cnt;
  logic [rdc_pkg::CNT_W-1:0]   cnt_m1;
  logic [rdc_pkg::DIV_W-1:0]   load_val;
  logic [rdc_pkg::DIGIT_W-1:0] digits [rdc_pkg::MAX_DIGITS];
  logic [rdc_pkg::DIGIT_W:0]   trial;

  assign base   = rdc_pkg::eff_base(radix);
  assign cnt_m1 = cnt - rdc_pkg::CNT_W'(1);

  always_comb begin
    load_val = '0;
    for (int i = 0; i < rdc_pkg::DIV_W; i++) begin
      if (i < rdc_pkg::VALUE_WIDTH && i < rdc_pkg::IN_W) begin
        load_val[i] = in_value[i];
      end
    end
  end

  // One remainder bit in, one quotient bit out, per step.
  always_comb begin
    quot_next = quot;
    rem_next  = rem;
    trial     = '0;
    for (int s = 0; s < rdc_pkg::STEP_BITS; s++) begin
      trial     = {rem_next, quot_next[rdc_pkg::DIV_W-1]};
      quot_next = {quot_next[rdc_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        trial        = trial - {1'b0, base};
        quot_next[0] = 1'b1;
      end
      rem_next = trial[rdc_pkg::DIGIT_W-1:0];
    end
  end

  assign sts.digit_end = (cyc == rdc_pkg::CYC_W'(rdc_pkg::DIV_CYCLES - 1));
  assign sts.conv_done = (quot_next == '0) ||
                         (cnt == rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS - 1));
  assign sts.emit_last = (cnt == rdc_pkg::CNT_W'(1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= rdc_pkg::RADIX_RESET;
      out_valid <= 1'b0;
      cyc       <= '0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      if (cmd.load) begin
        cyc <= '0;
        cnt <= '0;
      end else if (cmd.step) begin
        if (sts.digit_end) begin
          cyc <= '0;
          cnt <= cnt + rdc_pkg::CNT_W'(1);
        end else begin
          cyc <= cyc + rdc_pkg::CYC_W'(1);
        end
      end else if (cmd.emit) begin
        cnt <= cnt_m1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot <= load_val;
      rem  <= '0;
    end else if (cmd.step) begin
      quot <= quot_next;
      if (sts.digit_end) begin
        rem                                   <= '0;
        digits[cnt[rdc_pkg::IDX_W-1:0]] <= rem_next;
      end else begin
        rem <= rem_next;
      end
    end
    if (cmd.emit) begin
      out_char <= rdc_pkg::to_ascii(digits[cnt_m1[rdc_pkg::IDX_W-1:0]]);
      out_last <= sts.emit_last;
    end
  end

endmodule

// ===== hw/rtl/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value into ASCII digits of a configurable base.
// ----------------------------------------------------------------------------
// Each item on the slave stream is divided repeatedly by the radix register
// (2 to 36, values outside are clamped) and the resulting digits leave on the
// master stream most significant first, one item per digit, with tlast on the
// final digit; zero gives the single digit '0'. Digits are 0-9 then 'A'-'Z'.
// The shift-subtract divider retires 8 quotient bits per cycle for each digit,
// and the digit buffer then drains one digit per cycle while the master
// stream accepts. The next item is taken once the last digit sits in the
// output register.
module radix_digit_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0]     cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rdc_pkg::IN_W-1:0]        s_tdata,  // [31:0] value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rdc_pkg::OUT_W-1:0]       m_tdata,  // [6:0] digit_char, [7] zero
  output logic                            m_tlast
);

  rdc_pkg::rdc_cmd_t             cmd;
  rdc_pkg::rdc_status_t          sts;
  logic [rdc_pkg::CHAR_W-1:0]    out_char;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(rdc_pkg::OUT_W - rdc_pkg::CHAR_W){1'b0}}, out_char};

endmodule

// ===== tb/sv/radix_digit_converter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb
// Self-checking testbench of the radix digit converter.
// ----------------------------------------------------------------------------
// A short table of directed values runs first. It covers zero, the largest
// value, both ends of the base range and register values beyond either end.
// Random values follow under a series of radix settings. Each accepted value is
// expanded into its digit items by a local model of the conversion, unless its
// directed row types the digits. Every digit leaving the master stream is
// compared against the oldest expected digit. Both stream sides stall at random.
// There are three phases: a slow receiver, a slow sender, then no stalls at all.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIR = 20;
  localparam int BLOCKS_PER_PHASE = 4;
  localparam int ITEMS_PER_BLOCK = 11;

  typedef struct packed {
    logic [rdc_pkg::CHAR_W-1:0] code;
    logic last;
  } digit_t;

  typedef struct {
    logic [rdc_pkg::RADIX_W-1:0] radix;
    logic [rdc_pkg::IN_W-1:0] value;
    string text;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rdc_pkg::RADIX_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rdc_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rdc_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;

  digit_t expected_digits[$];
  logic [rdc_pkg::RADIX_W-1:0] model_radix = rdc_pkg::RADIX_RESET;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{6'd10, 32'd0, "0"},
    '{6'd10, 32'hFFFF_FFFF, "4294967295"},
    '{6'd10, 32'd1, "1"},
    '{6'd10, 32'd9, "9"},
    '{6'd10, 32'd10, "10"},
    '{6'd2, 32'hFFFF_FFFF, {"11111111", "11111111", "11111111", "11111111"}},
    '{6'd2, 32'd0, "0"},
    '{6'd2, 32'h8000_0000, ""},
    '{6'd0, 32'd5, "101"},
    '{6'd1, 32'd6, "110"},
    '{6'd36, 32'hFFFF_FFFF, "1Z141Z3"},
    '{6'd36, 32'd35, "Z"},
    '{6'd36, 32'd36, "10"},
    '{6'd37, 32'd35, "Z"},
    '{6'd63, 32'd71, "1Z"},
    '{6'd16, 32'hDEAD_BEEF, "DEADBEEF"},
    '{6'd16, 32'h0000_00FF, "FF"},
    '{6'd16, 32'h1234_5678, ""},
    '{6'd8, 32'hFFFF_FFFF, "37777777777"},
    '{6'd3, 32'h5A5A_5A5A, ""}
  };

  radix_digit_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic void push_expected_digits(input logic [rdc_pkg::IN_W-1:0] value,
                                               input logic [rdc_pkg::RADIX_W-1:0] radix);
    logic [rdc_pkg::IN_W-1:0] rest;
    logic [rdc_pkg::RADIX_W-1:0] base;
    logic [rdc_pkg::RADIX_W-1:0] d;
    digit_t lsd_first[$];
    digit_t item;
    rest = value;
    base = radix;
    if (base < rdc_pkg::RADIX_MIN) base = rdc_pkg::RADIX_MIN;
    if (base > rdc_pkg::RADIX_MAX) base = rdc_pkg::RADIX_MAX;
    if (rest == '0) begin
      lsd_first.push_back('{code: rdc_pkg::CHAR_ZERO, last: 1'b0});
    end
    while (rest != '0 && lsd_first.size() < rdc_pkg::MAX_DIGITS) begin
      d = rdc_pkg::RADIX_W'(rest % rdc_pkg::IN_W'(base));
      rest = rest / rdc_pkg::IN_W'(base);
      if (d < rdc_pkg::DEC_LIMIT) begin
        item.code = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(d);
      end else begin
        item.code = rdc_pkg::CHAR_A + rdc_pkg::CHAR_W'(d - rdc_pkg::DEC_LIMIT);
      end
      item.last = 1'b0;
      lsd_first.push_back(item);
    end
    for (int k = lsd_first.size() - 1; k >= 0; k--) begin
      item = lsd_first[k];
      item.last = (k == 0);
      expected_digits.push_back(item);
    end
  endfunction

  function automatic void push_typed_digits(input string text);
    digit_t item;
    for (int i = 0; i < text.len(); i++) begin
      item.code = rdc_pkg::CHAR_W'(text[i]);
      item.last = (i == text.len() - 1);
      expected_digits.push_back(item);
    end
  endfunction

  task automatic send_value(input logic [rdc_pkg::IN_W-1:0] value, input string text);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    if (text.len() > 0) begin
      push_typed_digits(text);
    end else begin
      push_expected_digits(value, model_radix);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic set_radix(input logic [rdc_pkg::RADIX_W-1:0] radix);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= radix;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_radix = radix;
  endtask

  function automatic logic [rdc_pkg::IN_W-1:0] random_value();
    logic [rdc_pkg::IN_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = $urandom_range(0, 40);
      default: v = $urandom | 32'h8000_0000;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    digit_t want;
    m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit, expected none, actual data %h last %b",
                 $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        want = expected_digits.pop_front();
        if (m_tdata != {1'b0, want.code}) begin
          $display("%0t: digit mismatch, expected %h, actual %h",
                   $time, {1'b0, want.code}, m_tdata);
          error_count++;
        end
        if (m_tlast != want.last) begin
          $display("%0t: last flag mismatch, expected %b, actual %b",
                   $time, want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [rdc_pkg::RADIX_W-1:0] radix;
    src_idle_pct = 20;
    snk_idle_pct = 85;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].radix != model_radix) set_radix(dir_rows[i].radix);
      send_value(dir_rows[i].value, dir_rows[i].text);
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 85 : 0;
      snk_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 20 : 0;
      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
        if (b == 0) begin
          radix = (phase == 0) ? 6'd2 : (phase == 1) ? 6'd36 : 6'd0;
        end else if (b == 1) begin
          radix = (phase == 0) ? 6'd63 : (phase == 1) ? 6'd1 : 6'd10;
        end else begin
          radix = rdc_pkg::RADIX_W'($urandom_range(0, 63));
        end
        set_radix(radix);
        for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
          send_value(random_value(), "");
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_digits.size() != 0) begin
      $display("%0t: %0d expected digits never arrived", $time, expected_digits.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
